/* sv/smws_pkg.sv */
// Package for the substring matcher with substitutions.
// Holds the item kind codes, character set types and the cell command struct.
// No dependencies.
package smws_pkg;

	localparam int CHAR_W          = 7;
	localparam int NUM_CHARS       = 1 << CHAR_W;
	localparam int MAX_PATTERN_DEF = 64;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_ADD_SUB = 2'd1,
		KIND_APPEND = 2'd2,
		KIND_TEXT   = 2'd3
	} kind_t;

	typedef logic [CHAR_W-1:0]    char_t;
	typedef logic [NUM_CHARS-1:0] char_set_t;

	// broadcast to every cell of the chain for one transfer
	typedef struct packed {
		logic  clr;
		logic  app;
		logic  sub;
		logic  txt;
		logic  eot;
		char_t ch1;
		char_t ch2;
	} cell_cmd_t;

	function automatic char_set_t char_bit(input char_t ch);
		char_bit = char_set_t'(1) << ch;
	endfunction

endpackage

/* sv/smws_ram.sv */
// Generic single-write, single-read RAM with per-bit write mask.
// Read data is registered. No dependencies.
module smws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [WIDTH-1:0]         wmask,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/smws_cell.sv */
// One pattern position of the shift-and chain: pattern char, its class set
// and the partial match bit handed to the next cell. Depends on smws_pkg.
module smws_cell
	import smws_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_cmd_t cmd,
	input  char_set_t row,
	input  logic      prev_valid,
	input  logic      prev_match,
	input  logic      next_valid,
	output logic      valid,
	output logic      match,
	output logic      hit
);

	logic      valid_q;
	logic      match_q;
	logic      pend_q;
	char_t     pat_q;
	char_set_t cls_q;
	logic      hit_s1;

	char_set_t cls;
	logic      load;
	logic      sub_hit;
	logic      match_nxt;
	logic      last;

	// class row arrives from the table in the cycle after the append
	assign cls       = pend_q ? (row | char_bit(pat_q)) : cls_q;
	assign load      = cmd.app & prev_valid & ~valid_q;
	assign sub_hit   = cmd.sub & valid_q & (pat_q == cmd.ch1);
	assign match_nxt = valid_q & prev_match & cls[cmd.ch1];
	assign last      = valid_q & ~next_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (cmd.clr) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			pend_q <= load;
			if (load) begin
				valid_q <= 1'b1;
				match_q <= 1'b0;
			end else if (cmd.txt) begin
				match_q <= cmd.eot ? 1'b0 : match_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		cls_q <= cls | (sub_hit ? char_bit(cmd.ch2) : '0);
		if (load) begin
			pat_q <= cmd.ch1;
		end
		if (cmd.txt) begin
			hit_s1 <= match_nxt & last;
		end
	end

	assign valid = valid_q;
	assign match = match_q;
	assign hit   = hit_s1;

endmodule

/* sv/substring_match_with_substitutions_top.sv */
// A text char transfer gives its result on out_valid via the stage-1 and output
// registers. One item is taken per cycle while in_ready is high; it is low
// while stage 1 holds a result and the output stalls. Clear, substitution and
// append items give no result. Reset clears pattern, partial matches, found
// flag and table row valid bits at once; no clearing pass, the first item is
// taken in the cycle after reset. Depends on smws_pkg, smws_cell and smws_ram.
module substring_match_with_substitutions_top
	import smws_pkg::*;
#(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [6:0]  first_char,
	input  logic [6:0]  second_char,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        match_ends_here,
	output logic        found_any,
	output logic        text_done
);

	logic      in_acc;
	logic      adv;
	kind_t     kind_in;
	cell_cmd_t cmd;

	logic [MAX_PATTERN-1:0] valid_w;
	logic [MAX_PATTERN-1:0] match_w;
	logic [MAX_PATTERN-1:0] hit_w;

	char_set_t row_valid_q;
	logic      rowv_s1;
	char_set_t rd_row;
	char_set_t row;

	logic v_s1;
	logic eot_s1;
	logic fresh_s1;
	logic empty_s1;
	logic fresh_q;
	logic found_q;
	logic out_valid_q;
	logic match_q;
	logic found_any_q;
	logic done_q;

	logic hit;
	logic found_nxt;

	assign kind_in = kind_t'(kind);
	assign adv     = ~out_valid_q | out_ready;
	assign in_ready = ~v_s1 | adv;
	assign in_acc  = in_valid & in_ready;

	always_comb begin
		cmd     = '0;
		cmd.eot = end_of_text;
		cmd.ch1 = first_char;
		cmd.ch2 = second_char;
		if (in_acc) begin
			case (kind_in)
				KIND_CLEAR:   cmd.clr = 1'b1;
				KIND_ADD_SUB: cmd.sub = 1'b1;
				KIND_APPEND:  cmd.app = 1'b1;
				KIND_TEXT:    cmd.txt = 1'b1;
				default:      cmd.clr = 1'b0;
			endcase
		end
	end

	// substitution table, one row of replacement chars per original char
	smws_ram #(
		.WIDTH(NUM_CHARS),
		.DEPTH(NUM_CHARS)
	) u_table (
		.clk   (clk),
		.we    (cmd.sub),
		.waddr (first_char),
		.wdata (char_bit(second_char)),
		.wmask (row_valid_q[first_char] ? char_bit(second_char) : '1),
		.re    (cmd.app),
		.raddr (first_char),
		.rdata (rd_row)
	);

	assign row = rd_row & {NUM_CHARS{rowv_s1}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (cmd.clr) begin
			row_valid_q <= '0;
		end else if (cmd.sub) begin
			row_valid_q <= row_valid_q | char_bit(first_char);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.app) begin
			rowv_s1 <= row_valid_q[first_char];
		end
	end

	for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
		logic pv;
		logic pm;
		logic nv;
		if (i == 0) begin : g_head
			assign pv = 1'b1;
			assign pm = 1'b1;
		end else begin : g_body
			assign pv = valid_w[i-1];
			assign pm = match_w[i-1];
		end
		if (i == MAX_PATTERN - 1) begin : g_tail
			assign nv = 1'b0;
		end else begin : g_next
			assign nv = valid_w[i+1];
		end
		smws_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.row        (row),
			.prev_valid (pv),
			.prev_match (pm),
			.next_valid (nv),
			.valid      (valid_w[i]),
			.match      (match_w[i]),
			.hit        (hit_w[i])
		);
	end

	assign hit       = empty_s1 | (|hit_w);
	assign found_nxt = (~fresh_s1 & found_q) | hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			fresh_q     <= 1'b1;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.txt) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (cmd.clr) begin
				fresh_q <= 1'b1;
			end else if (cmd.txt) begin
				fresh_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= v_s1;
				if (v_s1) begin
					found_q <= eot_s1 ? 1'b0 : found_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.txt) begin
			eot_s1   <= end_of_text;
			fresh_s1 <= fresh_q;
			empty_s1 <= ~valid_w[0];
		end
		if (adv && v_s1) begin
			match_q     <= hit;
			found_any_q <= found_nxt;
			done_q      <= eot_s1;
		end
	end

	assign out_valid       = out_valid_q;
	assign match_ends_here = match_q;
	assign found_any       = found_any_q;
	assign text_done       = done_q;

`ifndef SYNTH
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_w & (valid_w + 1'b1)) == '0)
		else $error("pattern cells not filled from the head");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |=> (valid_w == '0) && (match_w == '0))
		else $error("clear left pattern state");

	a_eot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.txt && end_of_text |=> match_w == '0)
		else $error("partial matches kept past end of text");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.txt && !valid_w[0] |=> v_s1 && hit)
		else $error("empty pattern did not match");
`endif

endmodule
